/* hw/rtl/prra_pkg.sv */
// shared constants, angle type and elaboration-time tables for the point rotator
`timescale 1ns / 1ps
`default_nettype none

package prra_pkg;

    localparam int ANG_FRAC    = 32;   // fraction bits of the residual angle, in degrees
    localparam int GUARD_BITS  = 8;    // extra fraction bits carried through the cordic
    localparam int GAIN_FRAC   = 30;   // fraction bits of the gain constant
    localparam int ANG_W       = 41;   // holds +/-90 degrees in Q32 with margin
    localparam int CHUNK_W     = 12;   // 2^12 is 1 mod 45, so chunks of 12 bits fold
    localparam int DEG_MOD     = 45;   // 360 degrees is 45 * 2^3
    localparam int RECIP_45    = 1457; // ceil(2^16 / 45)
    localparam int RECIP_W     = 11;
    localparam int RECIP_SHIFT = 16;
    localparam int MUL_SPLIT   = 32;   // gain product is cut at this bit
    localparam int FRONT_LAT   = 5;
    localparam int GAIN_LAT    = 5;

    // 180/pi in Q52
    localparam logic signed [63:0] DEG_Q52 = 64'sd246083499208 <<< 20;

    typedef logic signed [ANG_W-1:0] t_ang;

    // unsigned quotient by shift and subtract, only ever evaluated while elaborating
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] part;
        int          b;
        quo  = '0;
        part = '0;
        for (b = 63; b >= 0; b--) begin
            part = {part[63:0], num[b]};
            if (part >= {1'b0, den}) begin
                part   = part - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-idx) in degrees, Q32, alternating series rounded half up
    function automatic logic signed [63:0] atan_entry(input int idx);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int                 k;
        sum = '0;
        if (idx == 0) begin
            return 64'sd45 <<< ANG_FRAC;
        end
        for (k = 0; idx * (2 * k + 1) < 62; k++) begin
            term = $signed(udiv64(DEG_Q52 >>> (idx * (2 * k + 1)), 64'(2 * k + 1)));
            sum  = (k % 2 == 1) ? sum - term : sum + term;
        end
        return (sum + (64'sd1 <<< 19)) >>> 20;
    endfunction

    // reciprocal of the cordic gain in Q30
    function automatic logic [63:0] gain_q30(input int stages);
        logic [63:0] g2;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bv;
        int          i;
        int          j;
        g2 = 64'd1 << 60;
        for (i = 0; i < stages; i++) begin
            g2 = g2 - udiv64(g2, (64'd1 << (2 * i)) + 64'd1);
        end
        n   = g2;
        res = '0;
        bv  = 64'd1 << 62;
        for (j = 0; j < 32; j++) begin
            if (bv > n) begin
                bv = bv >> 2;
            end
        end
        for (j = 0; j < 32; j++) begin
            if (bv != 64'd0) begin
                if (n >= res + bv) begin
                    n   = n - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/prra_cordic_stage.sv */
// one registered micro-rotation of the cordic chain
`timescale 1ns / 1ps
`default_nettype none

module prra_cordic_stage #(
    parameter int CORD_W = 43,
    parameter int IDX    = 0
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [CORD_W-1:0]   i_x,
    input  logic signed [CORD_W-1:0]   i_y,
    input  prra_pkg::t_ang             i_ang,
    output logic signed [CORD_W-1:0]   o_x,
    output logic signed [CORD_W-1:0]   o_y,
    output prra_pkg::t_ang             o_ang
);
    import prra_pkg::*;

    localparam t_ang ATAN_I = t_ang'(atan_entry(IDX));

    logic signed [CORD_W-1:0] sx;
    logic signed [CORD_W-1:0] sy;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    t_ang                     r_ang;

    assign sx = i_x >>> IDX;
    assign sy = i_y >>> IDX;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_ang[ANG_W-1]) begin
                r_x   <= i_x - sy;
                r_y   <= i_y + sx;
                r_ang <= i_ang - ATAN_I;
            end else begin
                r_x   <= i_x + sy;
                r_y   <= i_y - sx;
                r_ang <= i_ang + ATAN_I;
            end
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_ang = r_ang;

endmodule

`default_nettype wire

/* hw/rtl/prra_gain.sv */
// gain compensation, rounding, pivot add-back and saturation for one coordinate
`timescale 1ns / 1ps
`default_nettype none

module prra_gain #(
    parameter int                               COORD_W = 32,
    parameter int                               CORD_W  = 43,
    parameter logic [prra_pkg::GAIN_FRAC-1:0]   GAIN_K  = '0
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [CORD_W-1:0]    i_v,
    input  logic signed [COORD_W-1:0]   i_piv,
    output logic signed [COORD_W-1:0]   o_res,
    output logic                        o_sat
);
    import prra_pkg::*;

    localparam int MAG_W  = 2 * MUL_SPLIT;
    localparam int PROD_W = MUL_SPLIT + GAIN_FRAC + 1;
    localparam int RW     = COORD_W + 2;
    localparam int SUMW   = COORD_W + 3;
    localparam int SHR    = GAIN_FRAC + GUARD_BITS - MUL_SPLIT;
    localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (GAIN_FRAC + GUARD_BITS - 1);
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    logic signed [CORD_W:0]       v_ext;
    logic signed [CORD_W:0]       v_abs;
    logic [PROD_W-1:0]            lo_prod;
    logic [PROD_W-1:0]            hi_sum;
    logic signed [SUMW-1:0]       piv_e;
    logic signed [SUMW-1:0]       mag_e;
    logic signed [SUMW-1:0]       res;
    logic [SUMW-COORD_W:0]        res_top;

    logic [MAG_W-1:0]             r_mag;
    logic [PROD_W-1:0]            r_lo;
    logic [MAG_W-MUL_SPLIT-1:0]   r_hi_m;
    logic [PROD_W-1:0]            r_hi;
    logic [PROD_W-MUL_SPLIT-1:0]  r_lo_c;
    logic [RW-1:0]                r_mag4;
    logic [3:0]                   r_neg;
    logic signed [COORD_W-1:0]    r_piv1;
    logic signed [COORD_W-1:0]    r_piv2;
    logic signed [COORD_W-1:0]    r_piv3;
    logic signed [COORD_W-1:0]    r_piv4;
    logic signed [COORD_W-1:0]    r_res;
    logic                         r_sat;

    always_comb begin
        v_ext   = (CORD_W + 1)'(i_v);
        v_abs   = v_ext[CORD_W] ? -v_ext : v_ext;
        lo_prod = PROD_W'(r_mag[MUL_SPLIT-1:0]) * PROD_W'(GAIN_K) + ROUND;
        hi_sum  = r_hi + PROD_W'(r_lo_c);
        piv_e   = SUMW'(r_piv4);
        mag_e   = $signed(SUMW'(r_mag4));
        res     = r_neg[3] ? piv_e - mag_e : piv_e + mag_e;
        res_top = res[SUMW-1:COORD_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // magnitude and sign
            r_mag    <= MAG_W'($unsigned(v_abs));
            r_neg[0] <= v_ext[CORD_W];
            r_piv1   <= i_piv;
            // low partial product with the rounding half
            r_lo     <= lo_prod;
            r_hi_m   <= r_mag[MAG_W-1:MUL_SPLIT];
            r_neg[1] <= r_neg[0];
            r_piv2   <= r_piv1;
            // high partial product
            r_hi     <= PROD_W'(r_hi_m) * PROD_W'(GAIN_K);
            r_lo_c   <= r_lo[PROD_W-1:MUL_SPLIT];
            r_neg[2] <= r_neg[1];
            r_piv3   <= r_piv2;
            // recombine and drop the fraction
            r_mag4   <= RW'(hi_sum >> SHR);
            r_neg[3] <= r_neg[2];
            r_piv4   <= r_piv3;
            // signed add-back of the pivot, clipped
            if ((&res_top) || !(|res_top)) begin
                r_res <= res[COORD_W-1:0];
                r_sat <= 1'b0;
            end else begin
                r_res <= res[SUMW-1] ? C_MIN : C_MAX;
                r_sat <= 1'b1;
            end
        end
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

/* hw/rtl/point_rotate_about_origin.sv */
// top level: planar rotation of a point about a pivot through a pipelined cordic
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+---------------------------------------------------
//  in      | i_valid | o_stall | i_in_x i_in_y i_in_z i_angle_deg i_pivot_x i_pivot_y
//  out     | o_valid | i_stall | o_out_x o_out_y o_out_z o_saturated
//
//  one item per cycle while the output is not stalled; the pipe is built from
//  the angle reduction front end, one cordic stage per micro-rotation and the
//  two-step gain multiply
//  reset is synchronous and clears the valid line and empties the input skid register
//  a stalled result freezes the whole pipe; one more item lands in the skid
//  register, after which o_stall is raised until the output drains
`timescale 1ns / 1ps
`default_nettype none

module point_rotate_about_origin #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [COORD_WIDTH-1:0]   i_in_x,
    input  logic signed [COORD_WIDTH-1:0]   i_in_y,
    input  logic signed [COORD_WIDTH-1:0]   i_in_z,
    input  logic signed [COORD_WIDTH-1:0]   i_angle_deg,
    input  logic signed [COORD_WIDTH-1:0]   i_pivot_x,
    input  logic signed [COORD_WIDTH-1:0]   i_pivot_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [COORD_WIDTH-1:0]   o_out_x,
    output logic signed [COORD_WIDTH-1:0]   o_out_y,
    output logic signed [COORD_WIDTH-1:0]   o_out_z,
    output logic                            o_saturated
);
    import prra_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int S       = CORDIC_STAGES;
    // 8 guard bits, one for a negated full-scale offset, two for cordic growth
    localparam int CW      = W + GUARD_BITS + 3;
    localparam int T       = FRONT_LAT + S + GAIN_LAT;
    localparam int PIV_LEN = FRONT_LAT + S;
    localparam int LOWW    = F + 3;
    localparam int NHI     = W - LOWW;
    localparam int NCH     = (NHI + CHUNK_W - 1) / CHUNK_W;
    localparam int POW_MOD = (1 << (NHI % CHUNK_W)) % DEG_MOD;
    localparam int SFIX    = DEG_MOD - POW_MOD;
    localparam int VW      = $clog2(NCH * ((1 << CHUNK_W) - 1) + DEG_MOD + 1);
    localparam int PW      = VW + RECIP_W;
    localparam int QW      = PW - RECIP_SHIFT;
    localparam int MW      = $clog2(DEG_MOD);
    localparam int RW      = MW + LOWW;
    localparam int RSW     = RW + 1;

    localparam logic [GAIN_FRAC-1:0] GAIN_K     = GAIN_FRAC'(gain_q30(CORDIC_STAGES));
    localparam logic [RW-1:0]        HALF_TURN  = RW'(64'd180 << F);
    localparam logic [RSW-1:0]       FULL_TURN  = RSW'(64'd360 << F);
    localparam logic signed [RSW-1:0] QUARTER   = RSW'(64'd90 << F);
    localparam logic signed [W-1:0]  C_MAX      = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0]  C_MIN      = {1'b1, {(W - 1){1'b0}}};

    // handshake and input skid
    logic                   acc;
    logic                   en;
    logic                   src_vld;
    logic                   r_sk_vld;
    logic signed [W-1:0]    r_sk_x;
    logic signed [W-1:0]    r_sk_y;
    logic signed [W-1:0]    r_sk_z;
    logic signed [W-1:0]    r_sk_a;
    logic signed [W-1:0]    r_sk_px;
    logic signed [W-1:0]    r_sk_py;
    logic signed [W-1:0]    src_x;
    logic signed [W-1:0]    src_y;
    logic signed [W-1:0]    src_z;
    logic signed [W-1:0]    src_a;
    logic signed [W-1:0]    src_px;
    logic signed [W-1:0]    src_py;

    // side lines that follow the item down the pipe
    logic [T-1:0]           r_vld;
    logic [T-1:0]           r_sat;
    logic signed [W-1:0]    r_zl  [T];
    logic signed [W-1:0]    r_pxl [PIV_LEN];
    logic signed [W-1:0]    r_pyl [PIV_LEN];

    // front end
    logic signed [W:0]          diff_x;
    logic signed [W:0]          diff_y;
    logic signed [W-1:0]        off_x;
    logic signed [W-1:0]        off_y;
    logic                       off_sat;
    logic [NCH*CHUNK_W-1:0]     a_pad;
    logic [VW-1:0]              a_sum;
    logic [PW-1:0]              q_prod;
    logic [VW+1:0]              q45;
    logic signed [VW+1:0]       rem;
    logic [MW-1:0]              digit;
    logic signed [RSW-1:0]      rs;
    logic signed [W:0]          dxe;
    logic signed [W:0]          dye;
    logic signed [W:0]          tx;
    logic signed [W:0]          ty;
    logic signed [RSW-1:0]      rq;

    logic signed [W-1:0]    r_dx1, r_dy1, r_dx2, r_dy2, r_dx3, r_dy3, r_dx4, r_dy4;
    logic [VW-1:0]          r_v1;
    logic [VW-1:0]          r_v2;
    logic [LOWW-1:0]        r_lo1;
    logic [LOWW-1:0]        r_lo2;
    logic [QW-1:0]          r_q2;
    logic [RW-1:0]          r_r3;
    logic signed [RSW-1:0]  r_rs4;
    logic signed [CW-1:0]   r_cx5;
    logic signed [CW-1:0]   r_cy5;
    t_ang                   r_z5;

    // cordic chain
    logic signed [CW-1:0]   c_x   [S+1];
    logic signed [CW-1:0]   c_y   [S+1];
    t_ang                   c_ang [S+1];

    logic                   sat_x;
    logic                   sat_y;

    assign o_stall = r_sk_vld;
    assign acc     = i_valid & ~r_sk_vld;
    assign en      = ~r_vld[T-1] | ~i_stall;
    assign src_vld = r_sk_vld | acc;

    assign src_x  = r_sk_vld ? r_sk_x  : i_in_x;
    assign src_y  = r_sk_vld ? r_sk_y  : i_in_y;
    assign src_z  = r_sk_vld ? r_sk_z  : i_in_z;
    assign src_a  = r_sk_vld ? r_sk_a  : i_angle_deg;
    assign src_px = r_sk_vld ? r_sk_px : i_pivot_x;
    assign src_py = r_sk_vld ? r_sk_py : i_pivot_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_vld <= 1'b0;
            r_vld    <= '0;
        end else begin
            if (en) begin
                r_sk_vld <= 1'b0;
                r_vld    <= {r_vld[T-2:0], src_vld};
            end else if (acc) begin
                r_sk_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && acc) begin
            r_sk_x  <= i_in_x;
            r_sk_y  <= i_in_y;
            r_sk_z  <= i_in_z;
            r_sk_a  <= i_angle_deg;
            r_sk_px <= i_pivot_x;
            r_sk_py <= i_pivot_y;
        end
    end

    // offset from the pivot, clipped, and the angle folded into 12-bit chunks
    always_comb begin
        diff_x  = (W + 1)'(src_x) - (W + 1)'(src_px);
        diff_y  = (W + 1)'(src_y) - (W + 1)'(src_py);
        off_x   = (diff_x[W] != diff_x[W-1]) ? (diff_x[W] ? C_MIN : C_MAX) : diff_x[W-1:0];
        off_y   = (diff_y[W] != diff_y[W-1]) ? (diff_y[W] ? C_MIN : C_MAX) : diff_y[W-1:0];
        off_sat = (diff_x[W] != diff_x[W-1]) | (diff_y[W] != diff_y[W-1]);
        a_pad   = (NCH * CHUNK_W)'(src_a[W-1:LOWW]);
        // a negative high part is its unsigned pattern minus 2^NHI
        a_sum   = src_a[W-1] ? VW'(SFIX) : '0;
        for (int c = 0; c < NCH; c++) begin
            a_sum = a_sum + VW'(a_pad[c*CHUNK_W +: CHUNK_W]);
        end
    end

    // remainder by 45 via reciprocal estimate and one correction
    always_comb begin
        q_prod = PW'(r_v1) * PW'(RECIP_45);
        q45    = (VW + 2)'(r_q2) * (VW + 2)'(DEG_MOD);
        rem    = $signed((VW + 2)'(r_v2) - q45);
        if (rem < 0) begin
            digit = MW'(rem + DEG_MOD);
        end else if (rem >= DEG_MOD) begin
            digit = MW'(rem - DEG_MOD);
        end else begin
            digit = MW'(rem);
        end
        rs = (r_r3 > HALF_TURN) ? $signed({1'b0, r_r3} - FULL_TURN) : $signed({1'b0, r_r3});
    end

    // quarter-turn pre-rotation into the cordic range
    always_comb begin
        dxe = (W + 1)'(r_dx4);
        dye = (W + 1)'(r_dy4);
        if (r_rs4 > QUARTER) begin
            tx = -dye;
            ty = dxe;
            rq = r_rs4 - QUARTER;
        end else if (r_rs4 < -QUARTER) begin
            tx = dye;
            ty = -dxe;
            rq = r_rs4 + QUARTER;
        end else begin
            tx = dxe;
            ty = dye;
            rq = r_rs4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx1 <= off_x;
            r_dy1 <= off_y;
            r_v1  <= a_sum;
            r_lo1 <= src_a[LOWW-1:0];

            r_dx2 <= r_dx1;
            r_dy2 <= r_dy1;
            r_v2  <= r_v1;
            r_lo2 <= r_lo1;
            r_q2  <= q_prod[PW-1:RECIP_SHIFT];

            r_dx3 <= r_dx2;
            r_dy3 <= r_dy2;
            r_r3  <= {digit, r_lo2};

            r_dx4 <= r_dx3;
            r_dy4 <= r_dy3;
            r_rs4 <= rs;

            r_cx5 <= CW'(tx) <<< GUARD_BITS;
            r_cy5 <= CW'(ty) <<< GUARD_BITS;
            r_z5  <= t_ang'(rq) <<< (ANG_FRAC - F);

            r_sat    <= {r_sat[T-2:0], off_sat};
            r_zl[0]  <= src_z;
            r_pxl[0] <= src_px;
            r_pyl[0] <= src_py;
            for (int k = 1; k < T; k++) begin
                r_zl[k] <= r_zl[k-1];
            end
            for (int k = 1; k < PIV_LEN; k++) begin
                r_pxl[k] <= r_pxl[k-1];
                r_pyl[k] <= r_pyl[k-1];
            end
        end
    end

    assign c_x[0]   = r_cx5;
    assign c_y[0]   = r_cy5;
    assign c_ang[0] = r_z5;

    for (genvar g = 0; g < S; g++) begin : g_stage
        prra_cordic_stage #(
            .CORD_W (CW),
            .IDX    (g)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (c_x[g]),
            .i_y   (c_y[g]),
            .i_ang (c_ang[g]),
            .o_x   (c_x[g+1]),
            .o_y   (c_y[g+1]),
            .o_ang (c_ang[g+1])
        );
    end

    prra_gain #(
        .COORD_W (W),
        .CORD_W  (CW),
        .GAIN_K  (GAIN_K)
    ) u_gain_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_v   (c_x[S]),
        .i_piv (r_pxl[PIV_LEN-1]),
        .o_res (o_out_x),
        .o_sat (sat_x)
    );

    prra_gain #(
        .COORD_W (W),
        .CORD_W  (CW),
        .GAIN_K  (GAIN_K)
    ) u_gain_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_v   (c_y[S]),
        .i_piv (r_pyl[PIV_LEN-1]),
        .o_res (o_out_y),
        .o_sat (sat_y)
    );

    assign o_valid     = r_vld[T-1];
    assign o_out_z     = r_zl[T-1];
    assign o_saturated = r_sat[T-1] | sat_x | sat_y;

endmodule

`default_nettype wire

/* hw/rtl/prra_checker.sv */
// port-level checks on the point rotator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module prra_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_stall,
    input logic                           i_out_valid,
    input logic                           i_out_stall,
    input logic signed [COORD_WIDTH-1:0]  i_out_x,
    input logic signed [COORD_WIDTH-1:0]  i_out_z,
    input logic                           i_out_sat
);

    // the skid register only fills when an item arrives against a stalled output
    a_skid_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_in_stall) |-> $past(i_in_valid) && $past(i_out_valid && i_out_stall))
        else $error("input stall raised without a stalled output");

    // once the output moves the skid is drained in the next cycle
    a_skid_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall && !i_out_stall |=> !i_in_stall)
        else $error("input stall held while output free");

    // a full skid register implies a result waiting at the output
    a_stall_needs_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid)
        else $error("input stalled with no result pending");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_z) && $stable(i_out_sat))
        else $error("stalled result changed");

endmodule

bind point_rotate_about_origin prra_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_prra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_x     (o_out_x),
    .i_out_z     (o_out_z),
    .i_out_sat   (o_saturated)
);

`default_nettype wire
